@@ sv/wsd_pkg.sv @@
// Shared types and constants for the work stealing task dispatcher.
// Used by the top module and wsd_scan through scoped names; no dependencies.
package wsd_pkg;

    // Default structural sizes
    localparam int WSD_MAX_WORKERS = 8;
    localparam int WSD_QUEUE_DEPTH = 16;

    // Fixed field widths of the ports
    localparam int TOKEN_W = 32;
    localparam int REQ_W   = 3;
    localparam int WC_W    = 4;
    localparam int QIDX_W  = 3;

    // Worker count after reset
    localparam logic [WC_W-1:0] WC_RESET = 4'd8;

    // Command codes
    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_FETCH  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BADWORKER = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_TOKRD,
        S_DONE
    } t_state;

    // Control from the sequencer to the shared compare unit
    typedef struct packed {
        logic clear;
        logic sample;
        logic fetch;
    } t_scan_ctl;

endpackage

@@ sv/work_stealing_task_dispatcher_top.sv @@
// Work stealing task dispatcher: one token FIFO per worker, shortest-queue submit, stealing fetch.
// The queues in use are scanned one descriptor read and compare per cycle via the compare unit;
// fetch starts at the requester's queue, stops at the first non-empty one; bad worker skips the scan.
// Throughput: one item at a time; the next item is taken once the result is in the output
// register. Reset (synchronous, active low) empties all queues and sets the worker count to 8.
// Depends on wsd_pkg, wsd_ram and wsd_scan.
module work_stealing_task_dispatcher_top #(
    parameter int MAX_WORKERS = wsd_pkg::WSD_MAX_WORKERS,
    parameter int QUEUE_DEPTH = wsd_pkg::WSD_QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration
    input  logic                        i_cfg_we,
    input  logic [wsd_pkg::WC_W-1:0]    i_cfg_wdata,
    // Input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [wsd_pkg::REQ_W-1:0]   i_requester,
    input  logic [wsd_pkg::TOKEN_W-1:0] i_task_token,
    // Output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic [wsd_pkg::QIDX_W-1:0]  o_queue_index,
    output logic [wsd_pkg::TOKEN_W-1:0] o_token_out
);

    localparam int QW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int NW = $clog2(MAX_WORKERS + 1);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = 2 * PW + CW;
    localparam int TD = MAX_WORKERS * QUEUE_DEPTH;
    localparam int AW = $clog2(TD);

    // Token address of slot p in queue q
    function automatic logic [AW-1:0] tok_addr(input logic [QW-1:0] q, input logic [PW-1:0] p);
        logic [16:0] a;
        a = 17'(q) * 17'(QUEUE_DEPTH) + 17'(p);
        return a[AW-1:0];
    endfunction

    // Ring pointer advance
    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        logic [PW:0] s;
        s = {1'b0, p} + 1'b1;
        return (s == (PW + 1)'(QUEUE_DEPTH)) ? '0 : s[PW-1:0];
    endfunction

    wsd_pkg::t_state    r_state, n_state;
    logic [wsd_pkg::WC_W-1:0]    r_wc, n_wc;
    logic                        r_cmd, n_cmd;
    logic [wsd_pkg::TOKEN_W-1:0] r_tok, n_tok;
    logic [NW-1:0]               r_n, n_n;
    logic [QW-1:0]               r_q, n_q;
    logic [NW-1:0]               r_issue, n_issue;
    logic [NW-1:0]               r_done, n_done;
    logic                        r_pend, n_pend;
    logic [QW-1:0]               r_pend_q, n_pend_q;
    logic                        r_pend_v, n_pend_v;
    logic [MAX_WORKERS-1:0]      r_qv, n_qv;
    wsd_pkg::t_status            r_res_status, n_res_status;
    logic [QW-1:0]               r_res_q, n_res_q;
    logic [wsd_pkg::TOKEN_W-1:0] r_res_tok, n_res_tok;
    logic                        r_o_valid, n_o_valid;
    wsd_pkg::t_status            r_o_status, n_o_status;
    logic [QW-1:0]               r_o_q, n_o_q;
    logic [wsd_pkg::TOKEN_W-1:0] r_o_tok, n_o_tok;

    logic [7:0]    wc8;
    logic [7:0]    act8;
    logic [7:0]    req8;
    logic [7:0]    q8;
    logic [7:0]    oq8;
    logic          accept;

    wsd_pkg::t_scan_ctl scan_ctl;
    logic          scan_take;
    logic          scan_found;
    logic [QW-1:0] best_q;
    logic [DW-1:0] best_desc;
    logic [DW-1:0] scan_desc;
    logic [CW-1:0] best_cnt;
    logic [PW-1:0] best_tail;
    logic [PW-1:0] best_head;

    logic          desc_we;
    logic [DW-1:0] desc_wdata;
    logic [DW-1:0] desc_rdata;
    logic          tok_we;
    logic [wsd_pkg::TOKEN_W-1:0] tok_rdata;

    // Number of queues in use, clamped to 1..MAX_WORKERS
    always_comb begin
        wc8 = {4'b0, r_wc};
        if (wc8 == 8'd0) begin
            act8 = 8'd1;
        end else if (wc8 > 8'(MAX_WORKERS)) begin
            act8 = 8'(MAX_WORKERS);
        end else begin
            act8 = wc8;
        end
    end

    assign req8   = {5'b0, i_requester};
    assign accept = i_in_valid && (r_state == wsd_pkg::S_IDLE);
    assign q8     = 8'(r_q) + 8'd1;

    // Descriptor fields of the chosen queue: head, tail, count
    assign best_cnt  = best_desc[CW-1:0];
    assign best_tail = best_desc[CW+PW-1:CW];
    assign best_head = best_desc[DW-1:CW+PW];

    // Descriptors of never-written queues read as zero
    assign scan_desc = r_pend_v ? desc_rdata : '0;

    // Sequencer: next state, scan control and RAM writes
    always_comb begin
        n_state      = r_state;
        n_wc         = r_wc;
        n_cmd        = r_cmd;
        n_tok        = r_tok;
        n_n          = r_n;
        n_q          = r_q;
        n_issue      = r_issue;
        n_done       = r_done;
        n_pend       = 1'b0;
        n_pend_q     = r_pend_q;
        n_pend_v     = r_pend_v;
        n_qv         = r_qv;
        n_res_status = r_res_status;
        n_res_q      = r_res_q;
        n_res_tok    = r_res_tok;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_q        = r_o_q;
        n_o_tok      = r_o_tok;
        scan_ctl.clear  = 1'b0;
        scan_ctl.sample = 1'b0;
        scan_ctl.fetch  = (r_cmd == wsd_pkg::CMD_FETCH);
        desc_we      = 1'b0;
        desc_wdata   = best_desc;
        tok_we       = 1'b0;

        if (i_cfg_we) begin
            n_wc = i_cfg_wdata;
        end

        // Output register drains independently of the sequencer
        if (!i_out_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            wsd_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd          = i_cmd;
                    n_tok          = i_task_token;
                    n_n            = act8[NW-1:0];
                    n_issue        = '0;
                    n_done         = '0;
                    scan_ctl.clear = 1'b1;
                    n_res_tok      = '0;
                    n_res_q        = '0;
                    if (i_cmd == wsd_pkg::CMD_FETCH) begin
                        n_q = req8[QW-1:0];
                    end else begin
                        n_q = '0;
                    end
                    if ((i_cmd == wsd_pkg::CMD_FETCH) && (req8 >= act8)) begin
                        n_res_status = wsd_pkg::ST_BADWORKER;
                        n_state      = wsd_pkg::S_DONE;
                    end else begin
                        n_state = wsd_pkg::S_SCAN;
                    end
                end
            end

            wsd_pkg::S_SCAN: begin
                // Issue one descriptor read per cycle, wrapping the queue index
                if (r_issue != r_n) begin
                    n_pend   = 1'b1;
                    n_pend_q = r_q;
                    n_pend_v = r_qv[r_q];
                    n_issue  = r_issue + 1'b1;
                    if (q8 == 8'(r_n)) begin
                        n_q = '0;
                    end else begin
                        n_q = q8[QW-1:0];
                    end
                end
                // Compare the descriptor read in the previous cycle
                if (r_pend) begin
                    scan_ctl.sample = 1'b1;
                    n_done          = r_done + 1'b1;
                    if ((n_done == r_n) || (scan_ctl.fetch && scan_take)) begin
                        n_pend  = 1'b0;
                        n_state = wsd_pkg::S_COMMIT;
                    end
                end
            end

            wsd_pkg::S_COMMIT: begin
                n_res_q = best_q;
                if (r_cmd == wsd_pkg::CMD_SUBMIT) begin
                    if (best_cnt == CW'(QUEUE_DEPTH)) begin
                        n_res_status = wsd_pkg::ST_FULL;
                        n_res_q      = '0;
                    end else begin
                        tok_we       = 1'b1;
                        desc_we      = 1'b1;
                        desc_wdata   = {best_head, next_slot(best_tail), best_cnt + 1'b1};
                        n_qv[best_q] = 1'b1;
                        n_res_status = wsd_pkg::ST_OK;
                    end
                    n_state = wsd_pkg::S_DONE;
                end else if (!scan_found) begin
                    n_res_status = wsd_pkg::ST_EMPTY;
                    n_res_q      = '0;
                    n_state      = wsd_pkg::S_DONE;
                end else begin
                    // Token read at the head is issued this cycle
                    desc_we      = 1'b1;
                    desc_wdata   = {next_slot(best_head), best_tail, best_cnt - 1'b1};
                    n_res_status = wsd_pkg::ST_OK;
                    n_state      = wsd_pkg::S_TOKRD;
                end
            end

            wsd_pkg::S_TOKRD: begin
                n_res_tok = tok_rdata;
                n_state   = wsd_pkg::S_DONE;
            end

            wsd_pkg::S_DONE: begin
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_q      = r_res_q;
                    n_o_tok    = r_res_tok;
                    n_state    = wsd_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = wsd_pkg::S_IDLE;
            end
        endcase
    end

    // State and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wsd_pkg::S_IDLE;
            r_wc      <= wsd_pkg::WC_RESET;
            r_pend    <= 1'b0;
            r_qv      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wc      <= n_wc;
            r_pend    <= n_pend;
            r_qv      <= n_qv;
            r_o_valid <= n_o_valid;
        end
        r_cmd        <= n_cmd;
        r_tok        <= n_tok;
        r_n          <= n_n;
        r_q          <= n_q;
        r_issue      <= n_issue;
        r_done       <= n_done;
        r_pend_q     <= n_pend_q;
        r_pend_v     <= n_pend_v;
        r_res_status <= n_res_status;
        r_res_q      <= n_res_q;
        r_res_tok    <= n_res_tok;
        r_o_status   <= n_o_status;
        r_o_q        <= n_o_q;
        r_o_tok      <= n_o_tok;
    end

    // Per-queue descriptor store: head, tail and count
    wsd_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_WORKERS),
        .AW    (QW)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (desc_we),
        .i_waddr (best_q),
        .i_wdata (desc_wdata),
        .i_raddr (r_q),
        .o_rdata (desc_rdata)
    );

    // Token store: QUEUE_DEPTH slots per queue
    wsd_ram #(
        .WIDTH (wsd_pkg::TOKEN_W),
        .DEPTH (TD),
        .AW    (AW)
    ) u_tok_ram (
        .i_clk   (i_clk),
        .i_we    (tok_we),
        .i_waddr (tok_addr(best_q, best_tail)),
        .i_wdata (r_tok),
        .i_raddr (tok_addr(best_q, best_head)),
        .o_rdata (tok_rdata)
    );

    // Shared compare unit
    wsd_scan #(
        .QW (QW),
        .DW (DW),
        .CW (CW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_q         (r_pend_q),
        .i_desc      (scan_desc),
        .o_take      (scan_take),
        .o_found     (scan_found),
        .o_best_q    (best_q),
        .o_best_desc (best_desc)
    );

    // Ports
    assign oq8           = 8'(r_o_q);
    assign o_in_stall    = (r_state != wsd_pkg::S_IDLE);
    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_queue_index = oq8[wsd_pkg::QIDX_W-1:0];
    assign o_token_out   = r_o_tok;

endmodule

@@ sv/wsd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the queue descriptors and the token store; no package dependency.
module wsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/wsd_scan.sv @@
// Shared compare unit that walks the queue descriptors one per cycle.
// Tracks the shortest queue on submit and the first non-empty queue on fetch; uses wsd_pkg.
module wsd_scan #(
    parameter int QW = 3,
    parameter int DW = 13,
    parameter int CW = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wsd_pkg::t_scan_ctl  i_ctl,
    input  logic [QW-1:0]       i_q,
    input  logic [DW-1:0]       i_desc,
    output logic                o_take,
    output logic                o_found,
    output logic [QW-1:0]       o_best_q,
    output logic [DW-1:0]       o_best_desc
);

    logic          r_have;
    logic          n_have;
    logic [QW-1:0] r_best_q;
    logic [QW-1:0] n_best_q;
    logic [DW-1:0] r_best_desc;
    logic [DW-1:0] n_best_desc;
    logic [CW-1:0] cnt;
    logic [CW-1:0] best_cnt;

    assign cnt      = i_desc[CW-1:0];
    assign best_cnt = r_best_desc[CW-1:0];

    // One compare per beat: strictly shorter wins on submit, first non-empty on fetch
    always_comb begin
        if (!r_have) begin
            o_take = i_ctl.fetch ? (cnt != '0) : 1'b1;
        end else begin
            o_take = i_ctl.fetch ? 1'b0 : (cnt < best_cnt);
        end
        n_have      = r_have;
        n_best_q    = r_best_q;
        n_best_desc = r_best_desc;
        if (i_ctl.clear) begin
            n_have = 1'b0;
        end else if (i_ctl.sample && o_take) begin
            n_have      = 1'b1;
            n_best_q    = i_q;
            n_best_desc = i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else begin
            r_have <= n_have;
        end
        r_best_q    <= n_best_q;
        r_best_desc <= n_best_desc;
    end

    assign o_found     = r_have;
    assign o_best_q    = r_best_q;
    assign o_best_desc = r_best_desc;

endmodule
